// ===== rtl/swbb_pkg.sv =====
package swbb_pkg;

    localparam int unsigned DEF_MAX_WINDOW  = 256;
    localparam int unsigned DEF_SAMPLE_BITS = 24;

    localparam int unsigned CFG_DATA_BITS = 9;
    localparam int unsigned CFG_IDX_BITS  = 1;
    localparam int unsigned BAND_BITS     = 4;
    localparam int unsigned MIDDLE_BITS   = 24;
    localparam int unsigned UPPER_BITS    = 27;
    localparam int unsigned LOWER_BITS    = 28;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BAND_WIDTH    = 1'b1;

    localparam logic [CFG_DATA_BITS-1:0] WINDOW_RESET = 9'd20;
    localparam logic [BAND_BITS-1:0]     BAND_RESET   = 4'd2;
    localparam logic [BAND_BITS-1:0]     BAND_MIN     = 4'd1;
    localparam logic [BAND_BITS-1:0]     BAND_MAX     = 4'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SQUARE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_MEANSQ,
        ST_VAR,
        ST_ROOT,
        ST_FINISH
    } t_state;

endpackage

// ===== rtl/sliding_window_bollinger_bands_top.sv =====
// Sliding-window Bollinger bands. Each request carries one unsigned Q16.8 sample and
// a restart flag that clears the window before the sample is taken in. The block
// keeps the last window_length samples in a ring memory along with a running sum
// and sum of squares, and answers every request with one result: the truncated
// mean and the mean plus and minus band_width times the truncated square root of
// the variance, or all zeros with ready_res low while the window is still filling.
// All arithmetic is bit serial: two squaring steps, a restoring divide and a
// square root; a request that finds the window not yet full skips the divide,
// the second squaring and the root. One request is in work at a time; a
// finished result waits in the output register while the next request is
// taken. Writing window_length restarts the series. Configuration may only be
// written while the block is idle.
module sliding_window_bollinger_bands_top #(
    parameter int unsigned MAX_WINDOW  = swbb_pkg::DEF_MAX_WINDOW,
    parameter int unsigned SAMPLE_BITS = swbb_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr,
    input  logic [swbb_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [swbb_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [SAMPLE_BITS-1:0]              i_sample,
    input  logic                                i_restart,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_ready_res,
    output logic [swbb_pkg::MIDDLE_BITS-1:0]    o_middle_band,
    output logic [swbb_pkg::UPPER_BITS-1:0]     o_upper_band,
    output logic signed [swbb_pkg::LOWER_BITS-1:0] o_lower_band
);
    import swbb_pkg::*;

    localparam int unsigned AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int unsigned NW  = $clog2(MAX_WINDOW + 1);
    localparam int unsigned SB  = SAMPLE_BITS;
    localparam int unsigned SW  = SB + NW;
    localparam int unsigned PW  = 2 * SB;
    localparam int unsigned QW  = PW + NW;
    localparam int unsigned CTW = $clog2(QW + 1);
    localparam int unsigned EW  = (SB + 5 > LOWER_BITS) ? SB + 5 : LOWER_BITS;

    // Configuration.
    logic [NW-1:0]        r_n;
    logic [BAND_BITS-1:0] r_band;

    // Window state.
    logic [SB-1:0] r_ring [MAX_WINDOW];
    logic [SB-1:0] r_rd;
    logic [AW-1:0] r_slot;
    logic [NW-1:0] r_fill;
    logic [SW-1:0] r_sum;
    logic [QW-1:0] r_sumsq;
    logic          r_full;

    // Request and serial datapath.
    t_state         r_state, n_state;
    logic [SB-1:0]  r_x;
    logic [SB-1:0]  r_ma, r_mb;      // multipliers, shift right
    logic [PW-1:0]  r_ca, r_cb;      // multiplicands, shift left
    logic [PW-1:0]  r_pa, r_pb;      // product accumulators
    logic [QW-1:0]  r_qs, r_qq;      // dividend / quotient shifters
    logic [NW-1:0]  r_rs, r_rq;      // division remainders
    logic [SB-1:0]  r_mean;
    logic [PW-1:0]  r_rad;           // radicand, consumed two bits a step
    logic [SB+1:0]  r_srem;
    logic [SB-1:0]  r_root;
    logic [CTW-1:0] r_cnt;

    // Output register.
    logic                   r_ov, r_ores;
    logic [MIDDLE_BITS-1:0] r_omid;
    logic [UPPER_BITS-1:0]  r_oup;
    logic [LOWER_BITS-1:0]  r_olow;

    logic          acc_in, out_free, last_step;
    logic [AW:0]   old_t;
    logic [AW-1:0] old_slot;
    logic [NW:0]   rs_sh, rq_sh;
    logic [SB+1:0] s_sh, s_trial;
    logic [EW-1:0] offset, up_sum, low_dif;
    logic [NW-1:0] win_val;
    logic [BAND_BITS-1:0] band_val;

    assign acc_in    = i_valid && o_ready;
    assign out_free  = !r_ov || i_ready;
    assign last_step = (r_cnt == CTW'(1));

    // Slot that leaves the window: write slot minus N, wrapped.
    assign old_t    = {1'b0, r_slot} + (AW+1)'(MAX_WINDOW) - (AW+1)'(r_n);
    assign old_slot = (old_t >= (AW+1)'(MAX_WINDOW)) ?
                      AW'(old_t - (AW+1)'(MAX_WINDOW)) : old_t[AW-1:0];

    // Restoring division steps for both sums.
    assign rs_sh = {r_rs, r_qs[QW-1]};
    assign rq_sh = {r_rq, r_qq[QW-1]};

    // Square root step: bring down two radicand bits, try root*4+1.
    assign s_sh    = {r_srem[SB-1:0], r_rad[PW-1 -: 2]};
    assign s_trial = {r_root, 2'b01};

    assign offset  = EW'(r_root) * EW'(r_band);
    assign up_sum  = EW'(r_mean) + offset;
    assign low_dif = EW'(r_mean) - offset;

    always_comb begin
        win_val = NW'(i_cfg_data);
        if (i_cfg_data == '0) begin
            win_val = NW'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_WINDOW)) begin
            win_val = NW'(MAX_WINDOW);
        end
        band_val = i_cfg_data[BAND_BITS-1:0];
        if (band_val < BAND_MIN) begin
            band_val = BAND_MIN;
        end else if (band_val > BAND_MAX) begin
            band_val = BAND_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:   n_state = ST_LOAD;
            ST_LOAD:   n_state = ST_SQUARE;
            ST_SQUARE: begin
                if (last_step) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = (r_fill < r_n) ? ST_FINISH : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (last_step) begin
                    n_state = ST_MEANSQ;
                end
            end
            ST_MEANSQ: begin
                if (last_step) begin
                    n_state = ST_VAR;
                end
            end
            ST_VAR:    n_state = ST_ROOT;
            ST_ROOT: begin
                if (last_step) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Ring memory: the leaving sample is read before the new one is written.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rd <= r_ring[old_slot];
            r_ring[r_slot] <= r_x;
        end
    end

    // Control state: configuration, window bookkeeping and the output flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n     <= NW'(WINDOW_RESET);
            r_band  <= BAND_RESET;
            r_slot  <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == ST_FINISH && out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_wr) begin
                if (i_cfg_idx == REG_WINDOW_LENGTH) begin
                    r_n     <= win_val;
                    r_slot  <= '0;
                    r_fill  <= '0;
                    r_sum   <= '0;
                    r_sumsq <= '0;
                end else begin
                    r_band <= band_val;
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (acc_in && i_restart) begin
                        r_slot  <= '0;
                        r_fill  <= '0;
                        r_sum   <= '0;
                        r_sumsq <= '0;
                    end
                end
                ST_READ: begin
                    r_slot <= (r_slot == AW'(MAX_WINDOW - 1)) ? '0 : r_slot + AW'(1);
                    if (r_fill < r_n) begin
                        r_fill <= r_fill + NW'(1);
                    end
                end
                ST_LOAD: begin
                    r_sum <= r_sum + SW'(r_x) - (r_full ? SW'(r_rd) : '0);
                end
                ST_UPDATE: begin
                    r_sumsq <= r_sumsq + QW'(r_pa) - QW'(r_pb);
                end
                default: ;
            endcase
        end
    end

    // Serial datapath; none of it needs a reset.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x <= i_sample;
            end
            ST_READ: begin
                r_full <= (r_fill >= r_n);
            end
            ST_LOAD: begin
                r_ma  <= r_x;
                r_ca  <= PW'(r_x);
                r_mb  <= r_full ? r_rd : '0;
                r_cb  <= PW'(r_full ? r_rd : '0);
                r_pa  <= '0;
                r_pb  <= '0;
                r_cnt <= CTW'(SB);
            end
            ST_SQUARE, ST_MEANSQ: begin
                if (r_ma[0]) begin
                    r_pa <= r_pa + r_ca;
                end
                if (r_mb[0]) begin
                    r_pb <= r_pb + r_cb;
                end
                r_ma  <= r_ma >> 1;
                r_mb  <= r_mb >> 1;
                r_ca  <= r_ca << 1;
                r_cb  <= r_cb << 1;
                r_cnt <= r_cnt - CTW'(1);
            end
            ST_UPDATE: begin
                r_qs  <= QW'(r_sum);
                r_qq  <= r_sumsq + QW'(r_pa) - QW'(r_pb);
                r_rs  <= '0;
                r_rq  <= '0;
                r_cnt <= CTW'(QW);
                r_mean <= '0;
                r_root <= '0;
            end
            ST_DIVIDE: begin
                if (rs_sh >= (NW+1)'(r_n)) begin
                    r_rs <= NW'(rs_sh - (NW+1)'(r_n));
                    r_qs <= {r_qs[QW-2:0], 1'b1};
                end else begin
                    r_rs <= NW'(rs_sh);
                    r_qs <= {r_qs[QW-2:0], 1'b0};
                end
                if (rq_sh >= (NW+1)'(r_n)) begin
                    r_rq <= NW'(rq_sh - (NW+1)'(r_n));
                    r_qq <= {r_qq[QW-2:0], 1'b1};
                end else begin
                    r_rq <= NW'(rq_sh);
                    r_qq <= {r_qq[QW-2:0], 1'b0};
                end
                if (last_step) begin
                    // Mean of samples fits the sample width; start mean squared.
                    r_ma  <= SB'(rs_sh >= (NW+1)'(r_n) ?
                             {r_qs[QW-2:0], 1'b1} : {r_qs[QW-2:0], 1'b0});
                    r_ca  <= PW'(SB'(rs_sh >= (NW+1)'(r_n) ?
                             {r_qs[QW-2:0], 1'b1} : {r_qs[QW-2:0], 1'b0}));
                    r_mb  <= '0;
                    r_cb  <= '0;
                    r_pa  <= '0;
                    r_pb  <= '0;
                    r_cnt <= CTW'(SB);
                end else begin
                    r_cnt <= r_cnt - CTW'(1);
                end
            end
            ST_VAR: begin
                r_mean <= SB'(r_qs);
                r_rad  <= (r_qq > QW'(r_pa)) ? PW'(r_qq - QW'(r_pa)) : '0;
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= CTW'(SB);
            end
            ST_ROOT: begin
                if (s_sh >= s_trial) begin
                    r_srem <= s_sh - s_trial;
                    r_root <= {r_root[SB-2:0], 1'b1};
                end else begin
                    r_srem <= s_sh;
                    r_root <= {r_root[SB-2:0], 1'b0};
                end
                r_rad <= r_rad << 2;
                r_cnt <= r_cnt - CTW'(1);
            end
            ST_FINISH: begin
                if (out_free) begin
                    r_ores <= !(r_fill < r_n);
                    r_omid <= MIDDLE_BITS'(EW'(r_mean));
                    r_oup  <= up_sum[UPPER_BITS-1:0];
                    r_olow <= low_dif[LOWER_BITS-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_valid       = r_ov;
    assign o_ready_res   = r_ores;
    assign o_middle_band = r_omid;
    assign o_upper_band  = r_oup;
    assign o_lower_band  = r_olow;

    // The fill count never passes the window length.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_n)
        else $error("fill count exceeds window length");

    // A result not marked ready carries all-zero bands.
    a_not_ready_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_ores) |-> (r_omid == '0 && r_oup == '0 && r_olow == '0))
        else $error("unready result carries nonzero bands");

    // A new request is taken only after the previous one has left the datapath.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> (r_state == ST_READ))
        else $error("accepted request did not enter the datapath");

endmodule

// ===== tb/sliding_window_bollinger_bands_top_tb.sv =====
`timescale 1ns / 100ps

// Bollinger band engine bench. A directed table covers reset defaults, sample
// extremes, restarts, window and band extremes and register clamping; a random
// phase follows with random series of random content. Every result is
// compared field by field against a behavioral predictor of the bands.
module sliding_window_bollinger_bands_top_tb;
    import swbb_pkg::*;

    localparam int unsigned HALF_PERIOD = 6;
    localparam int unsigned RAND_ITEMS  = 1450;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned SETTLE_CYCLES = 200;

    // One output record of the band engine.
    typedef struct packed {
        logic                         full;
        logic [MIDDLE_BITS-1:0]       middle;
        logic [UPPER_BITS-1:0]        upper;
        logic signed [LOWER_BITS-1:0] lower;
    } t_band;

    // One directed row. A configuration row writes a register instead of
    // issuing a request. When has_exp is set, the typed value is checked
    // against the predictor so that both must agree with the block.
    typedef struct {
        bit                     is_cfg;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0] data;
        logic [23:0]            sample;
        bit                     restart;
        bit                     has_exp;
        t_band                  exp_band;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_wr = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = REG_WINDOW_LENGTH;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [23:0]              i_sample = '0;
    logic                     i_restart = 1'b0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic                     o_ready_res;
    logic [MIDDLE_BITS-1:0]   o_middle_band;
    logic [UPPER_BITS-1:0]    o_upper_band;
    logic signed [LOWER_BITS-1:0] o_lower_band;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    sliding_window_bollinger_bands_top u_dut (.*);

    // Predictor state: its own ring, sums and register copies.
    logic [23:0] hist_ring [256];
    logic [31:0] win_sum;
    logic [55:0] win_sq_sum;
    logic [7:0]  wr_slot;
    int unsigned filled;
    int unsigned win_len;
    int unsigned band_mult;

    t_band band_queue[$];
    int    fail_count = 0;
    int    idle_cycles = 0;
    bit    rx_hold = 1'b0;
    bit    rx_random = 1'b1;
    bit    tx_random = 1'b1;

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic void clear_series();
        win_sum = 0;
        win_sq_sum = 0;
        wr_slot = 0;
        filled = 0;
    endfunction

    task automatic apply_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        int unsigned v;
        if (idx == REG_WINDOW_LENGTH) begin
            v = data;
            if (v < 1) v = 1;
            if (v > 256) v = 256;
            win_len = v;
            clear_series();
        end else begin
            v = data[BAND_BITS-1:0];
            if (v < BAND_MIN) v = BAND_MIN;
            if (v > BAND_MAX) v = BAND_MAX;
            band_mult = v;
        end
    endtask

    // Advances the predictor by one sample and returns the expected bands.
    function automatic t_band predict_bands(logic [23:0] x, bit restart);
        t_band       r;
        logic [7:0]  old_slot;
        logic [23:0] old;
        logic [63:0] mean, msq, m2, var_q, offset;
        if (restart) clear_series();
        if (filled >= win_len) begin
            old_slot = 8'(wr_slot - win_len);
            old = hist_ring[old_slot];
            win_sum = win_sum - old;
            win_sq_sum = win_sq_sum - 56'(old) * 56'(old);
        end
        hist_ring[wr_slot] = x;
        wr_slot = wr_slot + 1;
        win_sum = win_sum + x;
        win_sq_sum = win_sq_sum + 56'(x) * 56'(x);
        if (filled < win_len) filled++;
        r = '0;
        if (filled >= win_len) begin
            mean = 64'(win_sum) / win_len;
            msq = 64'(win_sq_sum) / win_len;
            m2 = mean * mean;
            var_q = (msq > m2) ? msq - m2 : 0;
            offset = isqrt64(var_q) * band_mult;
            r.full = 1'b1;
            r.middle = mean[MIDDLE_BITS-1:0];
            r.upper = UPPER_BITS'(mean + offset);
            r.lower = LOWER_BITS'(mean - offset);
        end
        return r;
    endfunction

    // Presents one request and holds it until the block takes it. Valid is
    // dropped only while the sender idles, so it never gets two updates in
    // one time step.
    task automatic send_sample(logic [23:0] x, bit restart);
        while (tx_random && ($urandom_range(99) < 35)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= x;
        i_restart <= restart;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        band_queue.insert(band_queue.size(), predict_bands(x, restart));
        @(negedge i_clk);
    endtask

    // Waits until every expected result has come back, plus the block's
    // latency so that the engine is really idle.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (band_queue.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        wait_drained();
        i_cfg_wr <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        apply_register(idx, data);
        @(negedge i_clk);
        i_cfg_wr <= 1'b0;
    endtask

    // Receiver side: random stalls, or a forced hold-off while rx_hold is set.
    always @(negedge i_clk) begin
        if (!i_rst_n || rx_hold) begin
            i_ready <= 1'b0;
        end else if (rx_random) begin
            i_ready <= ($urandom_range(99) >= 35);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Result checker and no-progress watchdog.
    always @(posedge i_clk) begin
        t_band want;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("FAIL sliding_window_bollinger_bands_top");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (band_queue.size() == 0) begin
                    $display("%0t: unexpected result", $time);
                    fail_count++;
                end else begin
                    want = band_queue.pop_front();
                    if (o_ready_res !== want.full) begin
                        $display("%0t: ready_res expected %0d got %0d", $time, want.full,
                                 o_ready_res);
                        fail_count++;
                    end
                    if (o_middle_band !== want.middle) begin
                        $display("%0t: middle expected %0d got %0d", $time, want.middle,
                                 o_middle_band);
                        fail_count++;
                    end
                    if (o_upper_band !== want.upper) begin
                        $display("%0t: upper expected %0d got %0d", $time, want.upper,
                                 o_upper_band);
                        fail_count++;
                    end
                    if (o_lower_band !== want.lower) begin
                        $display("%0t: lower expected %0d got %0d", $time, want.lower,
                                 o_lower_band);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Random series: mostly fixed-length runs with a restart at the head,
    // with noise samples and occasional broken series mixed in.
    task automatic random_series(int unsigned len);
        logic [23:0] base;
        logic [23:0] x;
        base = $urandom();
        for (int unsigned k = 0; k < len; k++) begin
            case ($urandom_range(3))
                0: x = $urandom();
                1: x = base;
                2: x = base ^ 24'($urandom_range(255));
                default: x = ($urandom_range(1)) ? 24'hFFFFFF : 24'h0;
            endcase
            send_sample(x, (k == 0) || ($urandom_range(199) == 0));
        end
    endtask

    t_row table_rows[$];
    t_band got_band;
    int unsigned sent;

    function automatic void add_row(t_row r);
        table_rows.insert(table_rows.size(), r);
    endfunction

    function automatic t_row sample_row(logic [23:0] x, bit restart);
        t_row r;
        r = '{default: '0};
        r.sample = x;
        r.restart = restart;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = d;
        return r;
    endfunction

    initial begin
        t_row r;
        win_len = WINDOW_RESET;
        band_mult = BAND_RESET;
        clear_series();
        foreach (hist_ring[k]) hist_ring[k] = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table. The first request after reset cannot fill a window
        // of 20, so its result is all zeros.
        r = sample_row(24'hFFFFFF, 1'b0); r.has_exp = 1; r.exp_band = '0;
        add_row(r);
        add_row(sample_row(24'h000000, 1'b1));
        // Window of one: the variance is zero so all bands equal the sample.
        add_row(cfg_row(REG_WINDOW_LENGTH, 9'd1));
        r = sample_row(24'hFFFFFF, 1'b0); r.has_exp = 1;
        r.exp_band = '{1'b1, 24'hFFFFFF, 27'hFFFFFF, 28'hFFFFFF};
        add_row(r);
        r = sample_row(24'h000000, 1'b1); r.has_exp = 1; r.exp_band = '{1'b1, 0, 0, 0};
        add_row(r);
        // A zero window length clamps to one.
        add_row(cfg_row(REG_WINDOW_LENGTH, 9'd0));
        r = sample_row(24'h000100, 1'b0); r.has_exp = 1;
        r.exp_band = '{1'b1, 24'h100, 27'h100, 28'h100};
        add_row(r);
        // Window of two with alternating extremes and the widest band, so the
        // lower band goes negative.
        add_row(cfg_row(REG_WINDOW_LENGTH, 9'd2));
        add_row(cfg_row(REG_BAND_WIDTH, 4'd15));
        add_row(sample_row(24'hFFFFFF, 1'b0));
        add_row(sample_row(24'h000000, 1'b0));
        add_row(sample_row(24'hFFFFFF, 1'b0));
        add_row(sample_row(24'h123456, 1'b1));
        add_row(sample_row(24'hABCDEF, 1'b0));
        // Band width of zero clamps to one.
        add_row(cfg_row(REG_BAND_WIDTH, 4'd0));
        add_row(sample_row(24'h000001, 1'b0));
        add_row(sample_row(24'h800000, 1'b0));
        // Oversized window length clamps to the ring size.
        add_row(cfg_row(REG_WINDOW_LENGTH, 9'h1FF));
        add_row(sample_row(24'h555555, 1'b0));
        add_row(cfg_row(REG_WINDOW_LENGTH, 9'd3));
        add_row(cfg_row(REG_BAND_WIDTH, 4'd10));
        add_row(sample_row(24'hAAAAAA, 1'b0));
        add_row(sample_row(24'h555555, 1'b0));
        add_row(sample_row(24'hFFFFFF, 1'b0));
        add_row(sample_row(24'h000000, 1'b0));

        foreach (table_rows[k]) begin
            if (table_rows[k].is_cfg) begin
                write_register(table_rows[k].idx, table_rows[k].data);
            end else begin
                send_sample(table_rows[k].sample, table_rows[k].restart);
                got_band = band_queue[$];
                if (table_rows[k].has_exp && got_band !== table_rows[k].exp_band) begin
                    $display("%0t: table row %0d expected %h predicted %h", $time, k,
                             table_rows[k].exp_band, got_band);
                    fail_count++;
                end
            end
        end

        // Random phase over several settings, the full ring among them.
        sent = 0;
        while (sent < RAND_ITEMS) begin
            int unsigned len;
            case ($urandom_range(5))
                0: write_register(REG_WINDOW_LENGTH, 9'(256));
                1: write_register(REG_WINDOW_LENGTH, 9'($urandom_range(1, 4)));
                default: write_register(REG_WINDOW_LENGTH, 9'($urandom_range(1, 40)));
            endcase
            write_register(REG_BAND_WIDTH, 4'($urandom_range(15)));
            len = (win_len == 256) ? 300 : win_len * 3 + $urandom_range(20);
            if (len > RAND_ITEMS - sent) len = RAND_ITEMS - sent;
            if (sent >= 400 && sent < 700) begin
                rx_random = 1'b0;
                tx_random = 1'b0;
            end else begin
                rx_random = 1'b1;
                tx_random = 1'b1;
            end
            // Long receiver hold-off while the sender keeps offering.
            if (sent == 0) begin
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (600) @(negedge i_clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            random_series(len);
            sent += len;
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("PASS sliding_window_bollinger_bands_top");
        end else begin
            $display("FAIL sliding_window_bollinger_bands_top");
        end
        $finish;
    end

endmodule
